/* rtl/core/sbsh_pkg.sv */
package sbsh_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned DigestWords = 8;

  localparam logic [7:0] PadMark = 8'h80;

  // byte position at which the length field starts, minus one
  localparam logic [5:0] LenStartM1 = 6'd55;
  localparam logic [5:0] LastPos = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWord = 3'd7;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StMark  = 7'b0000010,
    StZero  = 7'b0000100,
    StLen   = 7'b0001000,
    StRound = 7'b0010000,
    StFold  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [BlockBytes] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* rtl/core/sha256_byte_stream_hasher.sv */
// channel    dir  tdata               tuser          tlast
// s_axis     in   [7:0] message_byte  byte_present   end_of_message
// m_axis     out  [31:0] digest_word  -              word_last
//
// one byte beat is taken per cycle while idle; the 64th byte of a block starts
// the shared round unit: 64 rounds at one a cycle, then a fold into the hash
// value. an end mark adds the pad bytes (up to 64, or 72 with an extra block)
// and a round pass with a fold for each padded block, then eight digest beats.
// tready is low while rounds, padding or output are running; output beats
// hold under m_axis_tready_i low. reset is asynchronous, active low, and loads
// the initial hash value.
module sha256_byte_stream_hasher
  import sbsh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] message_byte
  input  logic        s_axis_tuser_i,   // [0] byte_present
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic        m_axis_tlast_o    // word_last
);

  state_e       state_q, state_d;
  state_e       ret_q, ret_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  bits_q, bits_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   ocnt_q, ocnt_d;
  word_t        chain_q [DigestWords];
  word_t        chain_d [DigestWords];
  word_t        v_q [DigestWords];
  word_t        v_d [DigestWords];
  logic [511:0] win_q, win_d;

  logic         s_hs, m_hs;
  logic         shift_en;
  logic [7:0]   shift_byte;
  state_e       after;
  logic [63:0]  len_shifted;
  word_t        w0, w1, w9, w14, w_new;
  word_t        t1, t2, ch, maj;

  assign s_hs = s_axis_tvalid_i && s_axis_tready_o;
  assign m_hs = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = chain_q[ocnt_q];
  assign m_axis_tlast_o  = (state_q == StOut) && (ocnt_q == LastWord);

  // length field goes out most significant byte first
  assign len_shifted = bits_q << {fill_q[2:0], 3'b000};

  // schedule window: word j sits at win_q[511-32j -: 32]
  assign w0  = win_q[511:480];
  assign w1  = win_q[479:448];
  assign w9  = win_q[223:192];
  assign w14 = win_q[63:32];
  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + RoundK[rnd_q] + w0;
  assign t2  = big_sigma0(v_q[0]) + maj;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    fill_d     = fill_q;
    bits_d     = bits_q;
    rnd_d      = rnd_q;
    ocnt_d     = ocnt_q;
    chain_d    = chain_q;
    v_d        = v_q;
    win_d      = win_q;
    shift_en   = 1'b0;
    shift_byte = 8'h00;
    after      = state_q;

    case (state_q)
      StIdle: begin
        if (s_hs) begin
          after = s_axis_tlast_i ? StMark : StIdle;
          if (s_axis_tuser_i) begin
            shift_en   = 1'b1;
            shift_byte = s_axis_tdata_i;
            bits_d     = bits_q + 64'd8;
          end else begin
            state_d = after;
          end
        end
      end
      StMark: begin
        shift_en   = 1'b1;
        shift_byte = PadMark;
        after      = (fill_q == LenStartM1) ? StLen : StZero;
      end
      StZero: begin
        shift_en = 1'b1;
        after    = (fill_q == LenStartM1) ? StLen : StZero;
      end
      StLen: begin
        shift_en   = 1'b1;
        shift_byte = len_shifted[63:56];
        after      = (fill_q == LastPos) ? StOut : StLen;
      end
      StRound: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        win_d  = {win_q[479:0], w_new};
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == LastRound) begin
          state_d = StFold;
        end
      end
      StFold: begin
        for (int i = 0; i < DigestWords; i++) begin
          chain_d[i] = chain_q[i] + v_q[i];
        end
        state_d = ret_q;
      end
      StOut: begin
        if (m_hs) begin
          ocnt_d = ocnt_q + 3'd1;
          if (ocnt_q == LastWord) begin
            state_d = StIdle;
            chain_d = InitHash;
            bits_d  = '0;
            fill_d  = '0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (shift_en) begin
      win_d = {win_q[503:0], shift_byte};
      if (fill_q == LastPos) begin
        // block complete: hand it to the round unit
        fill_d  = '0;
        state_d = StRound;
        ret_d   = after;
        rnd_d   = '0;
        v_d     = chain_q;
      end else begin
        fill_d  = fill_q + 6'd1;
        state_d = after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      fill_q  <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      ocnt_q  <= '0;
      chain_q <= InitHash;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      rnd_q   <= rnd_d;
      ocnt_q  <= ocnt_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    win_q <= win_d;
  end

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input taken while digest is being sent");

  a_round_to_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q == LastRound) |=> (state_q == StFold))
    else $error("round unit did not fold after the last round");

  a_len_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLen) |-> (fill_q >= 6'd56))
    else $error("length field outside the last eight bytes");

  a_digest_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_hs && m_axis_tlast_o) |=> (state_q == StIdle && fill_q == '0 && bits_q == '0))
    else $error("hasher not restarted after the digest");

  a_fill_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (fill_q == '0))
    else $error("digest sent with a partly filled block");

endmodule
